// ===== rtl/saffd_pkg.sv =====
// ----------------------------------------------------------------------------
// saffd_pkg
// Shared types and constants for the six-axis force frame decoder.
// ----------------------------------------------------------------------------
package saffd_pkg;

    // Frame layout
    localparam int CHANNELS     = 6;
    localparam int RAW_W        = 12;
    localparam int STORE_DEPTH  = 10;
    localparam int POS_W        = 4;
    localparam int CH_W         = 3;

    localparam logic [POS_W-1:0] POS_HUNT = 4'd0;
    localparam logic [POS_W-1:0] POS_LAST = 4'd11;

    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] LF_BYTE = 8'h0A;

    // Configuration registers
    localparam int HEADER_W = 8;
    localparam int GAIN_W   = 20;
    localparam int CFG_W    = 20;

    localparam logic [HEADER_W-1:0] HEADER_RESET = 8'h49;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 20'd642908;

    typedef enum logic {
        REG_FRAME_HEADER = 1'b0,
        REG_GAIN         = 1'b1
    } t_cfg_reg;

    // Result widths
    localparam int FORCE_W  = 26;
    localparam int TORQUE_W = 21;
    localparam int PROD_W   = RAW_W + GAIN_W;   // |raw| * gain

    // floor(q / 5) = (q * DIV5_RECIP) >> DIV5_SHIFT, exact for q < 2**22
    localparam int              DIV5_SHIFT = 22;
    localparam logic [19:0]     DIV5_RECIP = 20'd838861;

    // Queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // One decoded frame: trailer status and the six raw channels
    typedef struct packed {
        logic                             status;
        logic [CHANNELS-1:0][RAW_W-1:0]   raw;
    } t_frame;

endpackage

// ===== rtl/saffd_front.sv =====
// ----------------------------------------------------------------------------
// saffd_front
// Hunts for the header byte, collects the frame and unpacks the channels.
// ----------------------------------------------------------------------------
module saffd_front
    import saffd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_rx_byte,
    output logic                o_stall,
    input  logic [HEADER_W-1:0] i_frame_header,
    output logic                o_push,
    output t_frame              o_push_data,
    input  logic                i_full
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_bytes [STORE_DEPTH];
    logic             accept;
    logic             good;

    // Only the closing byte needs room in the queue
    assign o_stall = (r_pos == POS_LAST) && i_full;
    assign accept  = i_valid && !o_stall;

    // Position sequencing
    always_comb begin
        n_pos  = r_pos;
        o_push = 1'b0;
        if (accept) begin
            if (r_pos == POS_HUNT) begin
                if (i_rx_byte == i_frame_header) begin
                    n_pos = 4'd1;
                end
            end else if (r_pos < POS_LAST) begin
                n_pos = r_pos + 4'd1;
            end else begin
                n_pos  = POS_HUNT;
                o_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Frame byte store, bytes 1..10
    always_ff @(posedge i_clk) begin
        if (accept && r_pos != POS_HUNT && r_pos < POS_LAST) begin
            r_bytes[r_pos - 4'd1] <= i_rx_byte;
        end
    end

    // Trailer check and channel unpacking; bad frames carry zero channels
    assign good = (r_bytes[9] == CR_BYTE) && (i_rx_byte == LF_BYTE);

    always_comb begin
        o_push_data.status = !good;
        for (int p = 0; p < CHANNELS / 2; p++) begin
            o_push_data.raw[2*p]   = {r_bytes[3*p], r_bytes[3*p+1][7:4]};
            o_push_data.raw[2*p+1] = {r_bytes[3*p+1][3:0], r_bytes[3*p+2]};
        end
        if (!good) begin
            o_push_data.raw = '0;
        end
    end

endmodule

// ===== rtl/saffd_queue.sv =====
// ----------------------------------------------------------------------------
// saffd_queue
// Small frame queue decoupling the byte front from the scaling back end.
// ----------------------------------------------------------------------------
module saffd_queue
    import saffd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_frame  i_push_data,
    output logic    o_full,
    output logic    o_not_empty,
    input  logic    i_pop,
    output t_frame  o_pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return ptr + PTR_W'(1);
    endfunction

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/saffd_back.sv =====
// ----------------------------------------------------------------------------
// saffd_back
// Scales the six channels of a frame through one shared three-stage
// multiply pipeline and holds the finished result for the receiver.
// ----------------------------------------------------------------------------
module saffd_back
    import saffd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_not_empty,
    output logic                       o_pop,
    input  t_frame                     i_frame,
    input  logic [GAIN_W-1:0]          i_gain,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_status,
    output logic signed [FORCE_W-1:0]  o_force_x,
    output logic signed [FORCE_W-1:0]  o_force_y,
    output logic signed [FORCE_W-1:0]  o_force_z,
    output logic signed [TORQUE_W-1:0] o_torque_x,
    output logic signed [TORQUE_W-1:0] o_torque_y,
    output logic signed [TORQUE_W-1:0] o_torque_z
);

    localparam int Q_W    = PROD_W - 9;
    localparam int DPROD_W = Q_W + 20;

    // Control
    logic            r_busy;
    logic            r_issue;
    logic [CH_W-1:0] r_cnt;
    logic            r_a_v;
    logic            r_b_v;
    logic            r_valid;

    // Datapath
    t_frame                     r_frame;
    logic [CH_W-1:0]            r_a_ch;
    logic                       r_a_neg;
    logic [PROD_W-1:0]          r_a_p;
    logic [CH_W-1:0]            r_b_ch;
    logic                       r_b_neg;
    logic [FORCE_W-1:0]         r_b_force;
    logic [DPROD_W-1:0]         r_b_tprod;
    logic                       r_status;
    logic [FORCE_W-1:0]         r_force  [3];
    logic [TORQUE_W-1:0]        r_torque [3];

    logic [RAW_W-1:0]   raw;
    logic               neg;
    logic [RAW_W-1:0]   mag;
    logic [PROD_W+2:0]  times5;
    logic [FORCE_W-1:0] force_mag;
    logic [TORQUE_W-1:0] torque_mag;
    logic               out_take;
    logic               last_done;

    assign out_take  = r_valid && !i_stall;
    assign o_pop     = i_not_empty && !r_busy && !r_valid;
    assign last_done = r_b_v && (r_b_ch == CH_W'(CHANNELS - 1));

    // Issue stage: magnitude of the selected channel
    assign raw = r_frame.raw[r_cnt];
    assign neg = raw[RAW_W-1];
    assign mag = neg ? (~raw + RAW_W'(1)) : raw;

    // Force: p * 5 / 512
    assign times5    = {3'b000, r_a_p} + {1'b0, r_a_p, 2'b00};
    assign force_mag = times5[PROD_W+2:9];

    // Torque: (p / 512) / 5 through the reciprocal product
    assign torque_mag = r_b_tprod[DPROD_W-1:DIV5_SHIFT];

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_issue <= 1'b0;
            r_cnt   <= '0;
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_issue <= 1'b1;
                r_cnt   <= '0;
            end else if (r_issue) begin
                if (r_cnt == CH_W'(CHANNELS - 1)) begin
                    r_issue <= 1'b0;
                end
                r_cnt <= r_cnt + CH_W'(1);
            end
            r_a_v <= r_issue;
            r_b_v <= r_a_v;
            if (last_done) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end else if (out_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Pipeline datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame <= i_frame;
        end
        // stage A: magnitude times gain
        r_a_ch  <= r_cnt;
        r_a_neg <= neg;
        r_a_p   <= PROD_W'(mag) * PROD_W'(i_gain);
        // stage B: force scale and torque reciprocal product
        r_b_ch    <= r_a_ch;
        r_b_neg   <= r_a_neg;
        r_b_force <= force_mag;
        r_b_tprod <= DPROD_W'(r_a_p[PROD_W-1:9]) * DPROD_W'(DIV5_RECIP);
        // stage C: sign restore into the result register
        if (r_b_v) begin
            if (r_b_ch < CH_W'(3)) begin
                r_force[r_b_ch[1:0]] <= r_b_neg ? (~r_b_force + FORCE_W'(1)) : r_b_force;
            end else begin
                r_torque[2'(r_b_ch - CH_W'(3))] <=
                    r_b_neg ? (~torque_mag + TORQUE_W'(1)) : torque_mag;
            end
        end
        if (last_done) begin
            r_status <= r_frame.status;
        end
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_force_x  = r_force[0];
    assign o_force_y  = r_force[1];
    assign o_force_z  = r_force[2];
    assign o_torque_x = r_torque[0];
    assign o_torque_y = r_torque[1];
    assign o_torque_z = r_torque[2];

endmodule

// ===== rtl/six_axis_force_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// six_axis_force_frame_decoder
// Byte-stream frame decoder for a six-axis force/torque sensor.
// ----------------------------------------------------------------------------
// Input channel: one serial byte per transaction (i_valid / o_stall). Bytes
// are ignored until one equals the frame header; the next eleven bytes form
// the frame. The twelfth byte produces exactly one output transaction.
// Output channel (o_valid / i_stall): o_status 0 with six scaled channels
// for a CR LF trailer, o_status 1 with zero channels otherwise.
// Throughput: one byte per cycle while o_stall is low. A frame is at least
// twelve bytes. The back end issues the six channels one after another
// through its single shared multiply pipeline, drains it, presents the
// result and waits for it to be taken before the next frame leaves the queue.
// A stalled result holds in the output register; completed frames wait in a
// small queue and the input stalls only on a closing byte while that queue
// is full. Reset returns the decoder to header hunting, empties the queue,
// drops any pending result and restores header 0x49 and the default gain.
// Configuration writes are taken at any time the write enable is high.
// ----------------------------------------------------------------------------
module six_axis_force_frame_decoder
    import saffd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_rx_byte,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [CFG_W-1:0]           i_cfg_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_status,
    output logic signed [FORCE_W-1:0]  o_force_x,
    output logic signed [FORCE_W-1:0]  o_force_y,
    output logic signed [FORCE_W-1:0]  o_force_z,
    output logic signed [TORQUE_W-1:0] o_torque_x,
    output logic signed [TORQUE_W-1:0] o_torque_y,
    output logic signed [TORQUE_W-1:0] o_torque_z
);

    logic [HEADER_W-1:0] r_frame_header;
    logic [GAIN_W-1:0]   r_gain;

    logic   push;
    t_frame push_data;
    logic   full;
    logic   not_empty;
    logic   pop;
    t_frame pop_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_header <= HEADER_RESET;
            r_gain         <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_FRAME_HEADER: r_frame_header <= i_cfg_data[HEADER_W-1:0];
                REG_GAIN:         r_gain         <= i_cfg_data[GAIN_W-1:0];
                default:          r_gain         <= r_gain;
            endcase
        end
    end

    saffd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_rx_byte      (i_rx_byte),
        .o_stall        (o_stall),
        .i_frame_header (r_frame_header),
        .o_push         (push),
        .o_push_data    (push_data),
        .i_full         (full)
    );

    saffd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .o_not_empty (not_empty),
        .i_pop       (pop),
        .o_pop_data  (pop_data)
    );

    saffd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (not_empty),
        .o_pop       (pop),
        .i_frame     (pop_data),
        .i_gain      (r_gain),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_force_x   (o_force_x),
        .o_force_y   (o_force_y),
        .o_force_z   (o_force_z),
        .o_torque_x  (o_torque_x),
        .o_torque_y  (o_torque_y),
        .o_torque_z  (o_torque_z)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the six-axis force frame decoder.
// ----------------------------------------------------------------------------
// Serial bytes go in one transaction at a time. A scoreboard follows the
// header hunt and the frame store byte by byte, decodes each closed frame
// into six scaled channels or a bad-trailer status, and checks every output
// transaction field by field. A short directed run is followed by phases of
// mostly well-formed frames with random content, line noise and broken
// trailers, under several header/gain settings and input/output idling mixes.
// ----------------------------------------------------------------------------
module tb;
    import saffd_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_BYTES   = 410;

    // One decoded frame as the output port presents it
    typedef struct packed {
        logic                        status;
        logic signed [FORCE_W-1:0]   force_x;
        logic signed [FORCE_W-1:0]   force_y;
        logic signed [FORCE_W-1:0]   force_z;
        logic signed [TORQUE_W-1:0]  torque_x;
        logic signed [TORQUE_W-1:0]  torque_y;
        logic signed [TORQUE_W-1:0]  torque_z;
    } t_force_result;

    // ------------------------------------------------------------------------
    // Scoreboard: frame decoder mirror plus queue of pending frame results
    // ------------------------------------------------------------------------
    class force_frame_scoreboard;
        logic [HEADER_W-1:0] header;
        logic [GAIN_W-1:0]   gain;
        logic [POS_W-1:0]    pos;
        logic [7:0]          store [STORE_DEPTH];
        t_force_result       pending_q [$];
        int                  errors;

        function new();
            header = HEADER_RESET;
            gain   = GAIN_RESET;
            pos    = POS_HUNT;
            errors = 0;
            foreach (store[i]) store[i] = 8'h00;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_W-1:0] data);
            if (idx == REG_FRAME_HEADER) header = data[HEADER_W-1:0];
            else gain = data[GAIN_W-1:0];
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // Even channels: high byte + upper nibble; odd: lower nibble + low byte
        function logic signed [RAW_W-1:0] channel_raw(int k);
            int base;
            base = (k / 2) * 3;
            if (k % 2 == 0) return {store[base], store[base+1][7:4]};
            return {store[base+1][3:0], store[base+2]};
        endfunction

        // raw * gain * mul / div, truncated toward zero
        function longint unsigned scaled(logic signed [RAW_W-1:0] raw,
                                         int unsigned mul, int unsigned div);
            int              r;
            longint unsigned mag;
            longint unsigned q;
            r   = raw;
            mag = (r < 0) ? -r : r;
            q   = (mag * gain * mul) / div;
            if (r < 0) q = 64'd0 - q;
            return q;
        endfunction

        // Accepted input transaction
        function void note_byte(logic [7:0] b);
            t_force_result r;
            if (pos == POS_HUNT) begin
                if (b == header) pos = 4'd1;
                return;
            end
            if (pos != POS_LAST) begin
                store[pos - 1] = b;
                pos = pos + 4'd1;
                return;
            end
            // closing byte: judge trailer, emit one result
            pos = POS_HUNT;
            r = '0;
            if (store[STORE_DEPTH-1] != CR_BYTE || b != LF_BYTE) begin
                r.status = 1'b1;
            end else begin
                r.force_x  = FORCE_W'(scaled(channel_raw(0), 5, 512));
                r.force_y  = FORCE_W'(scaled(channel_raw(1), 5, 512));
                r.force_z  = FORCE_W'(scaled(channel_raw(2), 5, 512));
                r.torque_x = TORQUE_W'(scaled(channel_raw(3), 1, 2560));
                r.torque_y = TORQUE_W'(scaled(channel_raw(4), 1, 2560));
                r.torque_z = TORQUE_W'(scaled(channel_raw(5), 1, 2560));
            end
            pending_q.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [63:0] e,
                                    logic signed [63:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        // Accepted output transaction
        function void check_frame(t_force_result act);
            t_force_result exp_r;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d",
                         $time, act.status);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            compare_field("status",   exp_r.status,   act.status);
            compare_field("force_x",  exp_r.force_x,  act.force_x);
            compare_field("force_y",  exp_r.force_y,  act.force_y);
            compare_field("force_z",  exp_r.force_z,  act.force_z);
            compare_field("torque_x", exp_r.torque_x, act.torque_x);
            compare_field("torque_y", exp_r.torque_y, act.torque_y);
            compare_field("torque_z", exp_r.torque_z, act.torque_z);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [7:0]                  i_rx_byte;
    logic                        i_cfg_we;
    logic                        i_cfg_idx;
    logic [CFG_W-1:0]            i_cfg_data;
    logic                        o_valid;
    logic                        i_stall;
    logic                        o_status;
    logic signed [FORCE_W-1:0]   o_force_x;
    logic signed [FORCE_W-1:0]   o_force_y;
    logic signed [FORCE_W-1:0]   o_force_z;
    logic signed [TORQUE_W-1:0]  o_torque_x;
    logic signed [TORQUE_W-1:0]  o_torque_y;
    logic signed [TORQUE_W-1:0]  o_torque_z;

    force_frame_scoreboard sb = new();
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cycle_count    = 0;

    six_axis_force_frame_decoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_rx_byte  (i_rx_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_force_x  (o_force_x),
        .o_force_y  (o_force_y),
        .o_force_z  (o_force_z),
        .o_torque_x (o_torque_x),
        .o_torque_y (o_torque_y),
        .o_torque_z (o_torque_z)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("six_axis_force_frame_decoder regression: fail");
            $finish;
        end
    end

    // Output backpressure
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Monitor: note accepted bytes, check accepted results
    always @(posedge i_clk) begin
        t_force_result act;
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_byte(i_rx_byte);
            if (o_valid && !i_stall) begin
                act.status   = o_status;
                act.force_x  = o_force_x;
                act.force_y  = o_force_y;
                act.force_z  = o_force_z;
                act.torque_x = o_torque_x;
                act.torque_y = o_torque_y;
                act.torque_z = o_torque_z;
                sb.check_frame(act);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // One byte transaction, with random idle cycles ahead of it
    task automatic push_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid   <= 1'b0;
            i_rx_byte <= 8'($urandom_range(255));
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid and wait for every pending result
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Header, nine packed data bytes, two trailer bytes
    task automatic send_frame(input logic [CHANNELS-1:0][RAW_W-1:0] raw,
                              input logic [7:0] tail_a, input logic [7:0] tail_b);
        push_byte(sb.header);
        for (int p = 0; p < 3; p++) begin
            push_byte(raw[2*p][11:4]);
            push_byte({raw[2*p][3:0], raw[2*p+1][11:8]});
            push_byte(raw[2*p+1][7:0]);
        end
        push_byte(tail_a);
        push_byte(tail_b);
    endtask

    // Random channels, biased toward the extremes; mostly good trailers
    task automatic random_frame();
        logic [CHANNELS-1:0][RAW_W-1:0] raw;
        logic [7:0] ta;
        logic [7:0] tb_lf;
        for (int k = 0; k < CHANNELS; k++) begin
            case ($urandom_range(9))
                0: raw[k] = 12'h800;
                1: raw[k] = 12'h7FF;
                2: raw[k] = 12'h000;
                3: raw[k] = 12'hFFF;
                default: raw[k] = 12'($urandom_range(4095));
            endcase
        end
        ta    = CR_BYTE;
        tb_lf = LF_BYTE;
        case ($urandom_range(9))
            0: tb_lf = 8'($urandom_range(255));
            1: ta    = 8'($urandom_range(255));
            2: begin
                ta    = 8'($urandom_range(255));
                tb_lf = 8'($urandom_range(255));
            end
            default: ;
        endcase
        send_frame(raw, ta, tb_lf);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [CHANNELS-1:0][RAW_W-1:0] raw;
        int sent;

        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_rx_byte  = 8'h00;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_FRAME_HEADER;
        i_cfg_data = '0;
        i_stall    = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: noise while hunting, extreme channels with a header
        // value inside the frame, then a bad trailer
        push_byte(8'h00);
        push_byte(8'hFF);
        raw[0] = 12'h800;
        raw[1] = 12'h7FF;
        raw[2] = 12'h494;
        raw[3] = 12'hFFF;
        raw[4] = 12'h001;
        raw[5] = 12'h800;
        send_frame(raw, CR_BYTE, LF_BYTE);
        raw = '1;
        send_frame(raw, CR_BYTE, 8'h0B);

        // Random phases under different settings and idling
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            case (ph)
                0: begin
                    write_reg(REG_FRAME_HEADER, {12'($urandom_range(4095)), 8'h00});
                    write_reg(REG_GAIN, 20'hFFFFF);
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    write_reg(REG_FRAME_HEADER, {12'($urandom_range(4095)), 8'hFF});
                    write_reg(REG_GAIN, 20'h00000);
                    src_idle_pct   = 53;
                    sink_stall_pct = 0;
                end
                2: begin
                    write_reg(REG_FRAME_HEADER, 20'($urandom_range(1048575)));
                    write_reg(REG_GAIN, 20'($urandom_range(1048575)));
                    src_idle_pct   = 0;
                    sink_stall_pct = 53;
                end
                default: begin
                    write_reg(REG_FRAME_HEADER, {12'($urandom_range(4095)), HEADER_RESET});
                    write_reg(REG_GAIN, 20'($urandom_range(1048575)));
                    src_idle_pct   = 13;
                    sink_stall_pct = 13;
                end
            endcase

            sent = 0;
            while (sent < PHASE_BYTES) begin
                // occasionally hold off until the output side is empty
                if ($urandom_range(99) < 3) drain_results();
                if ($urandom_range(99) < 30) begin
                    repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
                end
                random_frame();
                sent += 12;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("six_axis_force_frame_decoder regression: pass");
        end else begin
            $display("six_axis_force_frame_decoder regression: fail");
        end
        $finish;
    end

endmodule
